>>> design/frame_scale_mirror_flip_engine_unit_defines.svh
// assertion macros for the frame scale mirror flip engine
`ifndef FRAME_SCALE_MIRROR_FLIP_ENGINE_UNIT_DEFINES_SVH
`define FRAME_SCALE_MIRROR_FLIP_ENGINE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define FSMFE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fsmfe check failed");

`define FSMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fsmfe check failed");

`else

`define FSMFE_ASSERT_NOW(lbl, clk, rst, ante, cons)

`define FSMFE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> design/fsmfe_pkg.sv
// types and constants shared by the frame scale mirror flip engine
package fsmfe_pkg;

   localparam int MAX_WIDTH  = 256;
   localparam int MAX_HEIGHT = 256;
   localparam int MAX_FACTOR = 8;

   localparam int COORD_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int ADDR_W   = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int COUNT_W  = ADDR_W + 1;
   localparam int REP_W    = $clog2(MAX_FACTOR);
   localparam int PIX_W    = 8;
   localparam int WORD_W   = 3 * PIX_W;
   localparam int MODE_W   = 3;
   localparam int FACTOR_W = 4;
   localparam int SIZE_W   = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [MODE_W-1:0] {
      MODE_SCALE_UP   = 3'd0,
      MODE_SCALE_DOWN = 3'd1,
      MODE_MIRROR     = 3'd2,
      MODE_FLIP       = 3'd3,
      MODE_ROTATE     = 3'd4
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MODE   = 2'd0,
      REG_FACTOR = 2'd1,
      REG_WIDTH  = 2'd2,
      REG_HEIGHT = 2'd3
   } reg_idx_type;

   typedef enum logic {
      KIND_LOAD  = 1'b0,
      KIND_FETCH = 1'b1
   } kind_type;

   typedef struct packed {
      logic [COUNT_W-1:0] total;
      logic               empty;
      logic [COORD_W-1:0] gw_m1;
      logic [ROW_W-1:0]   gh_m1;
      logic [REP_W-1:0]   rep_m1;
      logic [COORD_W-1:0] col0;
      logic [COORD_W-1:0] col_step;
      logic [ADDR_W-1:0]  row0;
      logic [ADDR_W-1:0]  row_step;
      logic               rotate;
   } cfg_type;

endpackage

>>> design/fsmfe_if.sv
// handshake channels of the frame scale mirror flip engine
interface fsmfe_req_if;
   import fsmfe_pkg::*;
   logic             valid;
   logic             ready;
   kind_type         kind;
   logic [PIX_W-1:0] red_in;
   logic [PIX_W-1:0] green_in;
   logic [PIX_W-1:0] blue_in;
   modport source (output valid, kind, red_in, green_in, blue_in, input ready);
   modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface fsmfe_rsp_if;
   import fsmfe_pkg::*;
   logic             valid;
   logic             ready;
   logic             valid_res;
   logic [PIX_W-1:0] red_out;
   logic [PIX_W-1:0] green_out;
   logic [PIX_W-1:0] blue_out;
   logic             row_end;
   logic             frame_end;
   modport source (output valid, valid_res, red_out, green_out, blue_out, row_end,
                   frame_end, input ready);
   modport sink   (input valid, valid_res, red_out, green_out, blue_out, row_end,
                   frame_end, output ready);
endinterface

interface fsmfe_csr_if;
   import fsmfe_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/frame_scale_mirror_flip_engine_unit.sv
// Frame scale / mirror / flip / channel-rotate engine, top level.
// Load beats write the frame into a 64K x 24 single-write, single-read frame store in raster
// order, one beat per cycle unless requests are held off. Fetch beats walk the transformed
// frame: the position counters form the store address with one add, the store returns the
// pixel from its registered read port and it is registered onto the response channel, so a
// fetch holds off requests until its response is taken; a load that follows a fetch waits
// the same. Each fetch gives exactly one response beat, with valid_res low when the frame is
// not fully loaded, has been emitted, or is empty after scale down; loads give none. A
// configuration write holds off requests while the derived frame geometry is registered.
`include "frame_scale_mirror_flip_engine_unit_defines.svh"

module frame_scale_mirror_flip_engine_unit (
   input  logic        clock,
   input  logic        reset,
   fsmfe_req_if.sink   req_bus,
   fsmfe_rsp_if.source rsp_bus,
   fsmfe_csr_if.sink   csr_bus
);
   import fsmfe_pkg::*;

   cfg_type             cfg;
   logic                cfg_restart;
   logic                settle;

   logic                req_fire;
   logic                load_fire;
   logic                fetch_fire;
   logic                restart;
   logic                full;
   logic                fetch_ok;

   logic [COUNT_W-1:0]  load_count_ff, load_count_in;
   logic [ADDR_W-1:0]   wr_addr;
   logic [COORD_W-1:0]  out_col_ff, out_col_in;
   logic [ROW_W-1:0]    out_row_ff, out_row_in;
   logic [REP_W-1:0]    col_rep_ff, col_rep_in;
   logic [REP_W-1:0]    row_rep_ff, row_rep_in;
   logic                emit_done_ff, emit_done_in;
   logic                fresh_ff, fresh_in;
   logic [COORD_W-1:0]  scol_ff, scol_in;
   logic [ADDR_W-1:0]   row_base_ff, row_base_in;
   logic [COORD_W-1:0]  eff_col;
   logic [ADDR_W-1:0]   eff_row;
   logic [ADDR_W-1:0]   rd_addr;
   logic [WORD_W-1:0]   rd_data;
   logic                col_rep_last;
   logic                col_last;
   logic                row_last;

   logic                pend_ff;
   logic                pend_ok_ff;
   logic                pend_rot_ff;
   logic                pend_row_end_ff;
   logic                pend_frame_end_ff;

   logic                rsp_valid_ff;
   logic                rsp_res_ff;
   logic [PIX_W-1:0]    rsp_red_ff;
   logic [PIX_W-1:0]    rsp_green_ff;
   logic [PIX_W-1:0]    rsp_blue_ff;
   logic                rsp_row_end_ff;
   logic                rsp_frame_end_ff;
   logic [PIX_W-1:0]    pix_r, pix_g, pix_b;

   fsmfe_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg),
      .restart (cfg_restart),
      .settle  (settle)
   );

   assign req_bus.ready = !pend_ff && !settle && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign load_fire     = req_fire && (req_bus.kind == KIND_LOAD);
   assign fetch_fire    = req_fire && (req_bus.kind == KIND_FETCH);
   assign restart       = load_fire || cfg_restart;

   assign full     = (load_count_ff >= cfg.total);
   assign fetch_ok = full && !emit_done_ff && !cfg.empty;
   assign wr_addr  = full ? '0 : load_count_ff[ADDR_W-1:0];

   assign eff_col = fresh_ff ? cfg.col0 : scol_ff;
   assign eff_row = fresh_ff ? cfg.row0 : row_base_ff;
   assign rd_addr = eff_row + ADDR_W'(eff_col);

   assign col_rep_last = (col_rep_ff == cfg.rep_m1);
   assign col_last     = col_rep_last && (out_col_ff == cfg.gw_m1);
   assign row_last     = (row_rep_ff == cfg.rep_m1) && (out_row_ff == cfg.gh_m1);

   fsmfe_store u_store (
      .clock   (clock),
      .wr_en   (load_fire),
      .wr_addr (wr_addr),
      .wr_data ({req_bus.red_in, req_bus.green_in, req_bus.blue_in}),
      .rd_en   (fetch_fire),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // load counter
   always_comb begin
      load_count_in = load_count_ff;
      if (load_fire) begin
         load_count_in = (full ? '0 : load_count_ff) + COUNT_W'(1);
      end
   end

   // output position walk
   always_comb begin
      out_col_in   = out_col_ff;
      out_row_in   = out_row_ff;
      col_rep_in   = col_rep_ff;
      row_rep_in   = row_rep_ff;
      emit_done_in = emit_done_ff;
      fresh_in     = fresh_ff;
      scol_in      = scol_ff;
      row_base_in  = row_base_ff;
      if (restart) begin
         out_col_in   = '0;
         out_row_in   = '0;
         col_rep_in   = '0;
         row_rep_in   = '0;
         emit_done_in = 1'b0;
         fresh_in     = 1'b1;
      end else if (fetch_fire && fetch_ok) begin
         fresh_in    = 1'b0;
         scol_in     = eff_col;
         row_base_in = eff_row;
         if (!col_rep_last) begin
            col_rep_in = col_rep_ff + REP_W'(1);
         end else begin
            col_rep_in = '0;
            if (out_col_ff != cfg.gw_m1) begin
               out_col_in = out_col_ff + COORD_W'(1);
               scol_in    = eff_col + cfg.col_step;
            end else begin
               out_col_in = '0;
               scol_in    = cfg.col0;
               if (row_rep_ff != cfg.rep_m1) begin
                  row_rep_in = row_rep_ff + REP_W'(1);
               end else begin
                  row_rep_in = '0;
                  if (out_row_ff != cfg.gh_m1) begin
                     out_row_in  = out_row_ff + ROW_W'(1);
                     row_base_in = eff_row + cfg.row_step;
                  end else begin
                     out_row_in   = '0;
                     emit_done_in = 1'b1;
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         out_col_ff    <= '0;
         out_row_ff    <= '0;
         col_rep_ff    <= '0;
         row_rep_ff    <= '0;
         emit_done_ff  <= 1'b0;
         fresh_ff      <= 1'b1;
      end else begin
         load_count_ff <= load_count_in;
         out_col_ff    <= out_col_in;
         out_row_ff    <= out_row_in;
         col_rep_ff    <= col_rep_in;
         row_rep_ff    <= row_rep_in;
         emit_done_ff  <= emit_done_in;
         fresh_ff      <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      scol_ff     <= scol_in;
      row_base_ff <= row_base_in;
   end

   // fetch in flight while the store read completes
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= fetch_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (fetch_fire) begin
         pend_ok_ff        <= fetch_ok;
         pend_rot_ff       <= cfg.rotate;
         pend_row_end_ff   <= fetch_ok && col_last;
         pend_frame_end_ff <= fetch_ok && col_last && row_last;
      end
   end

   always_comb begin
      pix_r = rd_data[3*PIX_W-1:2*PIX_W];
      pix_g = rd_data[2*PIX_W-1:PIX_W];
      pix_b = rd_data[PIX_W-1:0];
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rsp_res_ff       <= pend_ok_ff;
         rsp_row_end_ff   <= pend_row_end_ff;
         rsp_frame_end_ff <= pend_frame_end_ff;
         if (!pend_ok_ff) begin
            rsp_red_ff   <= '0;
            rsp_green_ff <= '0;
            rsp_blue_ff  <= '0;
         end else if (pend_rot_ff) begin
            rsp_red_ff   <= pix_b;
            rsp_green_ff <= pix_r;
            rsp_blue_ff  <= pix_g;
         end else begin
            rsp_red_ff   <= pix_r;
            rsp_green_ff <= pix_g;
            rsp_blue_ff  <= pix_b;
         end
      end
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.valid_res = rsp_res_ff;
   assign rsp_bus.red_out   = rsp_red_ff;
   assign rsp_bus.green_out = rsp_green_ff;
   assign rsp_bus.blue_out  = rsp_blue_ff;
   assign rsp_bus.row_end   = rsp_row_end_ff;
   assign rsp_bus.frame_end = rsp_frame_end_ff;

   `FSMFE_ASSERT_NEXT(a_fetch_holds_req, clock, reset, fetch_fire, pend_ff && !req_bus.ready)
   `FSMFE_ASSERT_NEXT(a_pend_to_rsp, clock, reset, pend_ff, rsp_bus.valid && !pend_ff)
   `FSMFE_ASSERT_NEXT(a_load_no_rsp, clock, reset, load_fire, !pend_ff)
   `FSMFE_ASSERT_NOW(a_frame_end_row_end, clock, reset,
      rsp_bus.valid && rsp_bus.frame_end, rsp_bus.valid_res && rsp_bus.row_end)

endmodule

>>> design/fsmfe_store.sv
// frame store memory, one write port and one registered read port
module fsmfe_store (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [fsmfe_pkg::ADDR_W-1:0] wr_addr,
   input  logic [fsmfe_pkg::WORD_W-1:0] wr_data,
   input  logic                         rd_en,
   input  logic [fsmfe_pkg::ADDR_W-1:0] rd_addr,
   output logic [fsmfe_pkg::WORD_W-1:0] rd_data
);
   import fsmfe_pkg::*;

   logic [WORD_W-1:0] mem [MAX_WIDTH*MAX_HEIGHT];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> design/fsmfe_cfg.sv
// configuration registers and the registered geometry derived from them
module fsmfe_cfg (
   input  logic               clock,
   input  logic               reset,
   fsmfe_csr_if.sink          csr_bus,
   output fsmfe_pkg::cfg_type cfg,
   output logic               restart,
   output logic               settle
);
   import fsmfe_pkg::*;

   logic [MODE_W-1:0]   mode_ff;
   logic [FACTOR_W-1:0] factor_ff;
   logic [SIZE_W-1:0]   width_ff;
   logic [SIZE_W-1:0]   height_ff;
   logic                settle_ff;
   cfg_type             cfg_ff;
   cfg_type             cfg_in;
   logic                csr_fire;
   logic [SIZE_W-1:0]   w_c;
   logic [SIZE_W-1:0]   h_c;
   logic [FACTOR_W-1:0] f_c;
   logic [SIZE_W-1:0]   gw;
   logic [SIZE_W-1:0]   gh;
   logic                is_down;
   logic [2*SIZE_W-1:0] total_full;
   logic [2*SIZE_W-1:0] row0_full;
   logic [SIZE_W+FACTOR_W-1:0] stride_down;

   // floor(v / f) for f in 1..8 by reciprocal multiply, exact for v up to 256
   function automatic logic [SIZE_W-1:0] div_factor(input logic [SIZE_W-1:0] v,
                                                    input logic [FACTOR_W-1:0] f);
      logic [16:0]        recip;
      logic [SIZE_W+16:0] prod;
      case (f)
         4'd2:    recip = 17'd32768;
         4'd3:    recip = 17'd21846;
         4'd4:    recip = 17'd16384;
         4'd5:    recip = 17'd13108;
         4'd6:    recip = 17'd10923;
         4'd7:    recip = 17'd9363;
         4'd8:    recip = 17'd8192;
         default: recip = 17'd65536;
      endcase
      prod = {{17{1'b0}}, v} * {{SIZE_W{1'b0}}, recip};
      return prod[SIZE_W+15:16];
   endfunction

   assign csr_bus.ready = 1'b1;
   assign csr_fire      = csr_bus.valid && csr_bus.ready;
   assign restart       = csr_fire;
   assign settle        = settle_ff;
   assign cfg           = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_SCALE_UP;
         factor_ff <= FACTOR_W'(1);
         width_ff  <= SIZE_W'(MAX_WIDTH);
         height_ff <= SIZE_W'(MAX_HEIGHT);
         settle_ff <= 1'b1;
      end else begin
         settle_ff <= csr_fire;
         if (csr_fire) begin
            case (reg_idx_type'(csr_bus.index))
               REG_MODE:   mode_ff   <= csr_bus.data[MODE_W-1:0];
               REG_FACTOR: factor_ff <= csr_bus.data[FACTOR_W-1:0];
               REG_WIDTH:  width_ff  <= csr_bus.data[SIZE_W-1:0];
               REG_HEIGHT: height_ff <= csr_bus.data[SIZE_W-1:0];
               default:    mode_ff   <= mode_ff;
            endcase
         end
      end
   end

   always_comb begin
      w_c = (width_ff == '0) ? SIZE_W'(1) :
            (width_ff > SIZE_W'(MAX_WIDTH)) ? SIZE_W'(MAX_WIDTH) : width_ff;
      h_c = (height_ff == '0) ? SIZE_W'(1) :
            (height_ff > SIZE_W'(MAX_HEIGHT)) ? SIZE_W'(MAX_HEIGHT) : height_ff;
      f_c = (factor_ff == '0) ? FACTOR_W'(1) :
            (factor_ff > FACTOR_W'(MAX_FACTOR)) ? FACTOR_W'(MAX_FACTOR) : factor_ff;
      is_down     = (mode_ff == MODE_SCALE_DOWN);
      gw          = is_down ? div_factor(w_c, f_c) : w_c;
      gh          = is_down ? div_factor(h_c, f_c) : h_c;
      total_full  = {{SIZE_W{1'b0}}, w_c} * {{SIZE_W{1'b0}}, h_c};
      row0_full   = {{SIZE_W{1'b0}}, h_c - SIZE_W'(1)} * {{SIZE_W{1'b0}}, w_c};
      stride_down = {{FACTOR_W{1'b0}}, w_c} * {{SIZE_W{1'b0}}, f_c};

      cfg_in.total  = total_full[COUNT_W-1:0];
      cfg_in.empty  = (gw == '0) || (gh == '0);
      cfg_in.gw_m1  = COORD_W'(gw - SIZE_W'(1));
      cfg_in.gh_m1  = ROW_W'(gh - SIZE_W'(1));
      cfg_in.rep_m1 = (mode_ff == MODE_SCALE_UP) ? REP_W'(f_c - FACTOR_W'(1)) : '0;
      cfg_in.rotate = (mode_ff == MODE_ROTATE);

      if (mode_ff == MODE_MIRROR) begin
         cfg_in.col0     = COORD_W'(w_c - SIZE_W'(1));
         cfg_in.col_step = '1;
      end else begin
         cfg_in.col0     = '0;
         cfg_in.col_step = is_down ? COORD_W'(f_c) : COORD_W'(1);
      end

      if (mode_ff == MODE_FLIP) begin
         cfg_in.row0     = row0_full[ADDR_W-1:0];
         cfg_in.row_step = ADDR_W'(0) - ADDR_W'(w_c);
      end else begin
         cfg_in.row0     = '0;
         cfg_in.row_step = is_down ? ADDR_W'(stride_down) : ADDR_W'(w_c);
      end
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

endmodule

>>> tb/frame_scale_mirror_flip_engine_unit_check.sv
// predictor and comparator for the response beats of the frame scale mirror flip engine
module frame_scale_mirror_flip_engine_unit_check (
   input  logic clock,
   input  logic reset,
   fsmfe_req_if req_bus,
   fsmfe_rsp_if rsp_bus,
   fsmfe_csr_if csr_bus,
   output int   errors,
   output int   waiting,
   output int   pixels_seen,
   output int   frames_seen
);
   import fsmfe_pkg::*;

   typedef struct packed {
      logic             valid_res;
      logic [PIX_W-1:0] red;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] blue;
      logic             row_end;
      logic             frame_end;
   } pixel_beat_type;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   bit [WORD_W-1:0]     frame_copy [STORE_DEPTH];
   pixel_beat_type      expected_pixels [$];
   int unsigned         load_count;
   int unsigned         out_row;
   int unsigned         out_col;
   int unsigned         row_repeat;
   int unsigned         col_repeat;
   bit                  emit_done;
   logic [MODE_W-1:0]   mode_reg;
   logic [FACTOR_W-1:0] factor_reg;
   logic [SIZE_W-1:0]   width_reg;
   logic [SIZE_W-1:0]   height_reg;
   int                  mismatch_count = 0;
   int                  pending_count = 0;
   int                  response_beats = 0;
   int                  pixel_count = 0;
   int                  frame_count = 0;

   assign errors      = mismatch_count;
   assign waiting     = pending_count;
   assign pixels_seen = pixel_count;
   assign frames_seen = frame_count;

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic restart_walk();
      out_row    = 0;
      out_col    = 0;
      row_repeat = 0;
      col_repeat = 0;
      emit_done  = 1'b0;
   endtask

   task automatic report_mismatch(string what, int got, int want);
      mismatch_count++;
      $display("response beat %0d: %s is %0d, expected %0d", response_beats, what, got, want);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (reg_idx_type'(idx))
         REG_MODE:   mode_reg   = value[MODE_W-1:0];
         REG_FACTOR: factor_reg = value[FACTOR_W-1:0];
         REG_WIDTH:  width_reg  = value[SIZE_W-1:0];
         REG_HEIGHT: height_reg = value[SIZE_W-1:0];
         default:    ;
      endcase
      restart_walk();
   endtask

   task automatic store_pixel();
      int unsigned total;
      total = clamp_to(width_reg, MAX_WIDTH) * clamp_to(height_reg, MAX_HEIGHT);
      // a complete frame is overwritten from the start
      if (load_count >= total) load_count = 0;
      frame_copy[load_count] = {req_bus.red_in, req_bus.green_in, req_bus.blue_in};
      load_count++;
      restart_walk();
   endtask

   task automatic predict_fetch();
      int unsigned    w, h, f, total, rep, step, gw, gh, srow, scol, addr;
      bit             last_col, last_row;
      bit [WORD_W-1:0] pix;
      pixel_beat_type beat;
      w     = clamp_to(width_reg, MAX_WIDTH);
      h     = clamp_to(height_reg, MAX_HEIGHT);
      f     = clamp_to(factor_reg, MAX_FACTOR);
      total = w * h;
      rep   = (mode_reg == MODE_SCALE_UP) ? f : 1;
      step  = (mode_reg == MODE_SCALE_DOWN) ? f : 1;
      gw    = w / step;
      gh    = h / step;
      beat  = '0;
      if (!(load_count < total || emit_done || gw == 0 || gh == 0 ||
            out_row >= gh || out_col >= gw)) begin
         scol = (mode_reg == MODE_MIRROR) ? (w - 1 - out_col) : out_col * step;
         srow = (mode_reg == MODE_FLIP) ? (h - 1 - out_row) : out_row * step;
         addr = srow * w + scol;
         pix  = frame_copy[addr];
         last_col = (out_col == gw - 1) && (col_repeat == rep - 1);
         last_row = (out_row == gh - 1) && (row_repeat == rep - 1);
         beat.valid_res = 1'b1;
         if (mode_reg == MODE_ROTATE) begin
            beat.red   = pix[7:0];
            beat.green = pix[23:16];
            beat.blue  = pix[15:8];
         end else begin
            beat.red   = pix[23:16];
            beat.green = pix[15:8];
            beat.blue  = pix[7:0];
         end
         beat.row_end   = last_col;
         beat.frame_end = last_col && last_row;
         col_repeat++;
         if (col_repeat >= rep) begin
            col_repeat = 0;
            out_col++;
            if (out_col >= gw) begin
               out_col = 0;
               row_repeat++;
               if (row_repeat >= rep) begin
                  row_repeat = 0;
                  out_row++;
                  if (out_row >= gh) begin
                     out_row   = 0;
                     emit_done = 1'b1;
                  end
               end
            end
         end
      end
      expected_pixels.insert(expected_pixels.size(), beat);
   endtask

   task automatic check_beat();
      pixel_beat_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("beat with no fetch outstanding", 1, 0);
      end else begin
         want = expected_pixels.pop_front();
         if (rsp_bus.valid_res !== want.valid_res)
            report_mismatch("valid_res", rsp_bus.valid_res, want.valid_res);
         if (rsp_bus.red_out !== want.red)
            report_mismatch("red_out", rsp_bus.red_out, want.red);
         if (rsp_bus.green_out !== want.green)
            report_mismatch("green_out", rsp_bus.green_out, want.green);
         if (rsp_bus.blue_out !== want.blue)
            report_mismatch("blue_out", rsp_bus.blue_out, want.blue);
         if (rsp_bus.row_end !== want.row_end)
            report_mismatch("row_end", rsp_bus.row_end, want.row_end);
         if (rsp_bus.frame_end !== want.frame_end)
            report_mismatch("frame_end", rsp_bus.frame_end, want.frame_end);
      end
      if (rsp_bus.valid_res === 1'b1) pixel_count++;
      if (rsp_bus.valid_res === 1'b1 && rsp_bus.frame_end === 1'b1) frame_count++;
      response_beats++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         load_count = 0;
         restart_walk();
         mode_reg   = MODE_SCALE_UP;
         factor_reg = FACTOR_W'(1);
         width_reg  = SIZE_W'(MAX_WIDTH);
         height_reg = SIZE_W'(MAX_HEIGHT);
         expected_pixels.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_beat();
         if (csr_bus.valid && csr_bus.ready) write_reg(csr_bus.index, csr_bus.data);
         if (req_bus.valid && req_bus.ready) begin
            if (req_bus.kind == KIND_LOAD) store_pixel();
            else predict_fetch();
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

>>> tb/frame_scale_mirror_flip_engine_unit_test.sv
// top of the frame scale mirror flip engine test: stimulus, flow control and verdict
module frame_scale_mirror_flip_engine_unit_test;
   import fsmfe_pkg::*;

   localparam int ITEM_TARGET    = 1650;
   localparam int SETTLE_CYCLES  = 4;
   localparam int DRAIN_CYCLES   = 8;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int OUTPUT_CAP     = 300;
   localparam int STEADY_FROM    = 1200;
   localparam int STEADY_TO      = 1400;
   localparam logic [MODE_W-1:0] MODE_SPARE = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fsmfe_req_if req_bus();
   fsmfe_rsp_if rsp_bus();
   fsmfe_csr_if csr_bus();

   int errors;
   int waiting;
   int pixels_seen;
   int frames_seen;

   int                  items_sent   = 0;
   int                  loads_sent   = 0;
   int                  csr_writes   = 0;
   int                  stall_cycles = 0;
   int unsigned         frame_fill   = 0;
   bit                  steady       = 1'b0;
   bit                  hold_request = 1'b0;
   logic [MODE_W-1:0]   cfg_mode     = MODE_SCALE_UP;
   logic [FACTOR_W-1:0] cfg_factor   = FACTOR_W'(1);
   logic [SIZE_W-1:0]   cfg_width    = SIZE_W'(MAX_WIDTH);
   logic [SIZE_W-1:0]   cfg_height   = SIZE_W'(MAX_HEIGHT);

   frame_scale_mirror_flip_engine_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_scale_mirror_flip_engine_unit_check pixel_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .errors      (errors),
      .waiting     (waiting),
      .pixels_seen (pixels_seen),
      .frames_seen (frames_seen)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic int unsigned frame_pixels(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      return clamp_to(w, MAX_WIDTH) * clamp_to(h, MAX_HEIGHT);
   endfunction

   function automatic int unsigned output_pixels(logic [MODE_W-1:0] m, logic [FACTOR_W-1:0] f,
                                                 logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      int unsigned ef, ew, eh;
      ef = clamp_to(f, MAX_FACTOR);
      ew = clamp_to(w, MAX_WIDTH);
      eh = clamp_to(h, MAX_HEIGHT);
      case (m)
         MODE_SCALE_UP:   return ew * eh * ef * ef;
         MODE_SCALE_DOWN: return (ew / ef) * (eh / ef);
         default:         return ew * eh;
      endcase
   endfunction

   // loads still missing before the current frame is complete, or a whole frame once it is complete
   function automatic int unsigned frame_left();
      int unsigned total;
      total = frame_pixels(cfg_width, cfg_height);
      return (frame_fill >= total) ? total : total - frame_fill;
   endfunction

   function automatic bit take_gap();
      return !steady && ($urandom_range(0, 99) < 36);
   endfunction

   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return SIZE_W'($urandom_range(MAX_WIDTH + 1, 511));
         2:       return SIZE_W'(MAX_WIDTH);
         default: return SIZE_W'($urandom_range(1, 6));
      endcase
   endfunction

   task automatic send_beat(kind_type k, logic [WORD_W-1:0] rgb);
      while (take_gap()) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = k;
      req_bus.red_in   = rgb[23:16];
      req_bus.green_in = rgb[15:8];
      req_bus.blue_in  = rgb[7:0];
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      items_sent++;
      if (k == KIND_LOAD) begin
         loads_sent++;
         if (frame_fill >= frame_pixels(cfg_width, cfg_height)) frame_fill = 0;
         frame_fill++;
      end
   endtask

   task automatic load_pixels(int unsigned n);
      repeat (n) send_beat(KIND_LOAD, WORD_W'($urandom));
   endtask

   task automatic fetch_pixels(int unsigned n);
      repeat (n) send_beat(KIND_FETCH, WORD_W'($urandom));
   endtask

   // registers only change with nothing in flight
   task automatic settle();
      req_bus.valid = 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(reg_idx_type idx, logic [CSR_DATA_W-1:0] value);
      while (take_gap()) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid = 1'b0;
      csr_writes++;
      case (idx)
         REG_MODE:   cfg_mode   = value[MODE_W-1:0];
         REG_FACTOR: cfg_factor = value[FACTOR_W-1:0];
         REG_WIDTH:  cfg_width  = value;
         REG_HEIGHT: cfg_height = value;
         default:    ;
      endcase
   endtask

   task automatic setup(logic [MODE_W-1:0] m, logic [FACTOR_W-1:0] f,
                        logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
      logic [CSR_DATA_W-1:0] mode_word, factor_word;
      mode_word                   = CSR_DATA_W'($urandom);
      mode_word[MODE_W-1:0]       = m;
      factor_word                 = CSR_DATA_W'($urandom);
      factor_word[FACTOR_W-1:0]   = f;
      settle();
      write_reg(REG_MODE, mode_word);
      write_reg(REG_FACTOR, factor_word);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   task automatic random_setup();
      logic [CSR_DATA_W-1:0] nm, nf, nw, nh;
      bit [3:0]              change;
      change = 4'($urandom_range(1, 15));
      nm = CSR_DATA_W'($urandom);
      nf = CSR_DATA_W'($urandom);
      if (!change[0]) nm[MODE_W-1:0] = cfg_mode;
      else if ($urandom_range(0, 9) < 8) nm[MODE_W-1:0] = MODE_W'($urandom_range(0, 4));
      else nm[MODE_W-1:0] = MODE_W'($urandom_range(5, 7));
      case ($urandom_range(0, 9))
         0:       nf[FACTOR_W-1:0] = '0;
         1:       nf[FACTOR_W-1:0] = FACTOR_W'($urandom_range(MAX_FACTOR + 1, 15));
         2:       nf[FACTOR_W-1:0] = FACTOR_W'($urandom_range(5, MAX_FACTOR));
         default: nf[FACTOR_W-1:0] = FACTOR_W'($urandom_range(1, 4));
      endcase
      if (!change[1]) nf[FACTOR_W-1:0] = cfg_factor;
      nw = change[2] ? pick_size() : cfg_width;
      nh = change[3] ? pick_size() : cfg_height;
      // keep frames short: only one side may be large
      if (frame_pixels(nw, nh) > MAX_WIDTH) begin
         if (clamp_to(nw, MAX_WIDTH) >= clamp_to(nh, MAX_HEIGHT)) begin
            nh = CSR_DATA_W'(1);
            change[3] = 1'b1;
         end else begin
            nw = CSR_DATA_W'(1);
            change[2] = 1'b1;
         end
      end
      if (output_pixels(nm[MODE_W-1:0], nf[FACTOR_W-1:0], nw, nh) > OUTPUT_CAP) begin
         nw = CSR_DATA_W'($urandom_range(1, 2));
         nh = CSR_DATA_W'($urandom_range(1, 2));
         change[3:2] = 2'b11;
      end
      settle();
      if (change[0]) write_reg(REG_MODE, nm);
      if (change[1]) write_reg(REG_FACTOR, nf);
      if (change[2]) write_reg(REG_WIDTH, nw);
      if (change[3]) write_reg(REG_HEIGHT, nh);
   endtask

   task automatic run_phase();
      int unsigned           shape, len;
      logic [CSR_DATA_W-1:0] mode_word;
      shape = $urandom_range(0, 9);
      if (shape == 8) begin
         repeat ($urandom_range(4, 16))
            send_beat(kind_type'($urandom_range(0, 1)), WORD_W'($urandom));
      end else if (shape == 7) begin
         // same stored frame, another mode
         mode_word = CSR_DATA_W'($urandom);
         mode_word[MODE_W-1:0] = MODE_W'($urandom_range(0, 7));
         if (output_pixels(mode_word[MODE_W-1:0], cfg_factor, cfg_width, cfg_height) > OUTPUT_CAP)
            mode_word[MODE_W-1:0] = MODE_MIRROR;
         settle();
         write_reg(REG_MODE, mode_word);
         fetch_pixels(output_pixels(cfg_mode, cfg_factor, cfg_width, cfg_height) + 1);
      end else begin
         random_setup();
         len = output_pixels(cfg_mode, cfg_factor, cfg_width, cfg_height);
         if (shape == 9) begin
            load_pixels($urandom_range(0, frame_left() - 1));
            fetch_pixels($urandom_range(1, 3));
         end else if (shape == 6) begin
            load_pixels(frame_left());
            fetch_pixels(len / 2);
            load_pixels($urandom_range(1, 3));
            fetch_pixels(2);
            load_pixels(frame_left());
            fetch_pixels(len + 1);
         end else begin
            load_pixels(frame_left());
            fetch_pixels(len + $urandom_range(0, 2));
         end
      end
   endtask

   // response side flow control, with one long hold-off on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_bus.ready = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end
         rsp_bus.ready = steady || ($urandom_range(0, 99) >= 36);
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("no beat accepted for %0d cycles", WATCHDOG_LIMIT);
         $display("frame_scale_mirror_flip_engine_unit: mismatch");
         $finish;
      end
   end

   initial begin
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_LOAD;
      req_bus.red_in   = '0;
      req_bus.green_in = '0;
      req_bus.blue_in  = '0;
      csr_bus.valid    = 1'b0;
      csr_bus.index    = REG_MODE;
      csr_bus.data     = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // nothing loaded yet
      send_beat(KIND_FETCH, '0);
      setup(MODE_ROTATE, FACTOR_W'(1), SIZE_W'(2), SIZE_W'(2));
      send_beat(KIND_LOAD, 24'h000000);
      send_beat(KIND_LOAD, 24'hFFFFFF);
      send_beat(KIND_LOAD, 24'hFF0000);
      send_beat(KIND_LOAD, 24'h0000FF);
      fetch_pixels(2);
      // register write restarts the walk, then one fetch past the end
      settle();
      write_reg(REG_MODE, CSR_DATA_W'(MODE_MIRROR));
      fetch_pixels(5);
      // load into a full frame starts a new one
      send_beat(KIND_LOAD, 24'hFFFFFF);
      fetch_pixels(1);

      setup(MODE_MIRROR, FACTOR_W'(1), SIZE_W'(MAX_WIDTH), SIZE_W'(1));
      load_pixels(frame_left());
      fetch_pixels(MAX_WIDTH + 1);
      setup(MODE_FLIP, FACTOR_W'(1), SIZE_W'(0), SIZE_W'(511));
      load_pixels(frame_left());
      fetch_pixels(16);
      // decimation down to an empty frame
      setup(MODE_SCALE_DOWN, FACTOR_W'(15), SIZE_W'(5), SIZE_W'(0));
      load_pixels(frame_left());
      fetch_pixels(2);
      setup(MODE_SPARE, FACTOR_W'(0), SIZE_W'(3), SIZE_W'(2));
      load_pixels(frame_left());
      fetch_pixels(7);
      setup(MODE_SCALE_UP, FACTOR_W'(MAX_FACTOR), SIZE_W'(1), SIZE_W'(2));
      load_pixels(frame_left());
      fetch_pixels(2 * MAX_FACTOR * MAX_FACTOR + 1);

      // response side stalls long enough to back up the request side
      setup(MODE_SCALE_UP, FACTOR_W'(2), SIZE_W'(4), SIZE_W'(4));
      load_pixels(frame_left());
      hold_request = 1'b1;
      fetch_pixels(65);

      while (items_sent < ITEM_TARGET) begin
         steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);
         run_phase();
      end
      steady = 1'b0;

      req_bus.valid = 1'b0;
      while (waiting != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d request beats (%0d loads, %0d fetches), %0d register writes",
               items_sent, loads_sent, items_sent - loads_sent, csr_writes);
      $display("%0d output pixels returned, %0d output frames completed",
               pixels_seen, frames_seen);
      if (errors == 0 && waiting == 0) begin
         $display("frame_scale_mirror_flip_engine_unit: match");
      end else begin
         $display("frame_scale_mirror_flip_engine_unit: mismatch");
      end
      $finish;
   end

endmodule
